>>> hw/rtl/srbs_pkg.sv
// shared widths, reset values and codes for the retry backoff scheduler
package srbs_pkg;

  localparam int TIME_W     = 32;
  localparam int TALLY_W    = 16;
  localparam int OPCODE_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0]  FLOOR_MS         = TIME_W'(1000);
  localparam logic [TIME_W-1:0]  NEVER            = '1;
  localparam logic [TIME_W-1:0]  RST_INTERVAL     = TIME_W'(3600000);
  localparam logic [TIME_W-1:0]  RST_RETRY_BASE   = TIME_W'(30000);
  localparam logic [TIME_W-1:0]  RST_RETRY_CAP    = TIME_W'(1800000);
  localparam logic [TIME_W-1:0]  RST_RELINK_GAP   = TIME_W'(60000);
  localparam logic [TIME_W-1:0]  RST_RETRY_DELAY  = TIME_W'(1000);
  localparam logic [TALLY_W-1:0] TALLY_MAX        = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 3'd0,
    OP_LINK     = 3'd1,
    OP_SYNC_NOW = 3'd2,
    OP_RESULT   = 3'd3,
    OP_APPLY    = 3'd4
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_ENABLED  = 3'd0,
    REG_SYNC_INTERVAL = 3'd1,
    REG_RETRY_BASE    = 3'd2,
    REG_RETRY_CAP     = 3'd3,
    REG_RELINK_GAP    = 3'd4
  } cfg_reg_t;

endpackage

>>> hw/rtl/srbs_if.sv
// valid/ready channel interfaces for events, status and configuration writes

interface srbs_evt_if;
  logic                            valid;
  logic                            ready;
  logic [srbs_pkg::OPCODE_W-1:0]   opcode;
  logic [srbs_pkg::TIME_W-1:0]     now_ms;
  logic                            flag;

  modport source (output valid, output opcode, output now_ms, output flag, input ready);
  modport sink   (input valid, input opcode, input now_ms, input flag, output ready);
endinterface

interface srbs_status_if;
  logic                            valid;
  logic                            ready;
  logic                            sync_request;
  logic [srbs_pkg::TIME_W-1:0]     since_last_sync;
  logic [srbs_pkg::TIME_W-1:0]     next_sync_in;
  logic [srbs_pkg::TALLY_W-1:0]    success_count;
  logic [srbs_pkg::TALLY_W-1:0]    failure_count;
  logic                            synced_ever;

  modport source (output valid, output sync_request, output since_last_sync,
                  output next_sync_in, output success_count, output failure_count,
                  output synced_ever, input ready);
  modport sink   (input valid, input sync_request, input since_last_sync,
                  input next_sync_in, input success_count, input failure_count,
                  input synced_ever, output ready);
endinterface

interface srbs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [srbs_pkg::CFG_IDX_W-1:0]    index;
  logic [srbs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/sync_retry_backoff_scheduler_top.sv
// sync scheduler with exponential retry backoff, one status request per event
// an accepted event's status is registered and offered in the cycle after it is taken
// throughput: one event per cycle unless status stalls; status frees itself as taken
// rst (synchronous, active high) loads the default settings, clears link,
// outstanding and history state and sets the retry delay to the floor
module sync_retry_backoff_scheduler_top (
  input  logic                 clk,
  input  logic                 rst,
  srbs_cfg_if.sink             cfg,
  srbs_evt_if.sink             evt,
  srbs_status_if.source        status
);

  localparam int TW = srbs_pkg::TIME_W;
  localparam int CW = srbs_pkg::TALLY_W;

  // staged settings, written by the configuration channel
  logic          sync_enabled;
  logic [TW-1:0] sync_interval;
  logic [TW-1:0] retry_base;
  logic [TW-1:0] retry_cap;
  logic [TW-1:0] relink_gap;

  // active settings, latched with their floors by an apply event
  logic          act_enabled,  act_enabled_next;
  logic [TW-1:0] act_interval, act_interval_next;
  logic [TW-1:0] act_base,     act_base_next;
  logic [TW-1:0] act_cap,      act_cap_next;
  logic [TW-1:0] act_gap,      act_gap_next;

  // scheduler state
  logic          link_usable,     link_usable_next;
  logic          awaiting_answer, awaiting_answer_next;
  logic          has_synced,      has_synced_next;
  logic [TW-1:0] last_sync_time,  last_sync_time_next;
  logic [TW-1:0] next_due_time,   next_due_time_next;
  logic [TW-1:0] retry_delay,     retry_delay_next;
  logic [CW-1:0] success_tally,   success_tally_next;
  logic [CW-1:0] failure_tally,   failure_tally_next;

  // status computed for the event in flight
  logic          req_next;
  logic [TW-1:0] since_next;
  logic [TW-1:0] until_next;
  logic [TW-1:0] due_diff_next;

  // clamped settings as an apply would latch them
  logic [TW-1:0] interval_cl;
  logic [TW-1:0] base_cl;
  logic [TW-1:0] cap_cl;

  // arithmetic on the current state
  logic [TW-1:0] since_cur;
  logic [TW-1:0] due_diff;
  logic [TW-1:0] gap_diff;
  logic          due_reached;
  logic          gap_reached;

  logic          evt_accept;
  logic          status_valid;

  // a deadline d is reached at now when (now - d) has its top bit clear;
  // in terms of diff = d - now that is diff zero, or top bit set but not alone
  function automatic logic reached_by_diff(input logic [TW-1:0] diff);
    return (diff == '0) || (diff[TW-1] && (diff[TW-2:0] != '0));
  endfunction

  // configuration writes are always taken; unknown indexes fall through
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_enabled  <= 1'b0;
      sync_interval <= srbs_pkg::RST_INTERVAL;
      retry_base    <= srbs_pkg::RST_RETRY_BASE;
      retry_cap     <= srbs_pkg::RST_RETRY_CAP;
      relink_gap    <= srbs_pkg::RST_RELINK_GAP;
    end else if (cfg.valid) begin
      case (cfg.index)
        srbs_pkg::REG_SYNC_ENABLED:  sync_enabled  <= cfg.data[0];
        srbs_pkg::REG_SYNC_INTERVAL: sync_interval <= cfg.data[TW-1:0];
        srbs_pkg::REG_RETRY_BASE:    retry_base    <= cfg.data[TW-1:0];
        srbs_pkg::REG_RETRY_CAP:     retry_cap     <= cfg.data[TW-1:0];
        srbs_pkg::REG_RELINK_GAP:    relink_gap    <= cfg.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // floors: interval and base at least one second, cap at least the base
  assign interval_cl = (sync_interval < srbs_pkg::FLOOR_MS) ? srbs_pkg::FLOOR_MS
                                                            : sync_interval;
  assign base_cl     = (retry_base < srbs_pkg::FLOOR_MS) ? srbs_pkg::FLOOR_MS : retry_base;
  assign cap_cl      = (retry_cap < base_cl) ? base_cl : retry_cap;

  // wrap-aware time differences
  assign since_cur   = evt.now_ms - last_sync_time;
  assign due_diff    = next_due_time - evt.now_ms;
  assign gap_diff    = since_cur - act_gap;
  assign due_reached = reached_by_diff(due_diff);
  assign gap_reached = ~gap_diff[TW-1];

  // status register frees itself as the downstream takes it
  assign evt.ready  = ~status_valid | status.ready;
  assign evt_accept = evt.valid & evt.ready;

  always_comb begin
    act_enabled_next     = act_enabled;
    act_interval_next    = act_interval;
    act_base_next        = act_base;
    act_cap_next         = act_cap;
    act_gap_next         = act_gap;
    link_usable_next     = link_usable;
    awaiting_answer_next = awaiting_answer;
    has_synced_next      = has_synced;
    last_sync_time_next  = last_sync_time;
    next_due_time_next   = next_due_time;
    retry_delay_next     = retry_delay;
    success_tally_next   = success_tally;
    failure_tally_next   = failure_tally;
    req_next             = 1'b0;
    due_diff_next        = due_diff;
    since_next           = has_synced ? since_cur : srbs_pkg::NEVER;

    case (evt.opcode)
      srbs_pkg::OP_TICK: begin
        if (act_enabled && link_usable && !awaiting_answer && due_reached) begin
          awaiting_answer_next = 1'b1;
          req_next             = 1'b1;
        end
      end
      srbs_pkg::OP_LINK: begin
        // only a real change of link state does anything
        if (evt.flag != link_usable) begin
          link_usable_next = evt.flag;
          if (evt.flag) begin
            if (!has_synced) begin
              next_due_time_next = evt.now_ms;
              due_diff_next      = '0;
            end else if (gap_reached && !due_reached) begin
              // long enough away: pull the deadline in to now
              next_due_time_next = evt.now_ms;
              due_diff_next      = '0;
            end
          end
        end
      end
      srbs_pkg::OP_SYNC_NOW: begin
        next_due_time_next = evt.now_ms;
        due_diff_next      = '0;
      end
      srbs_pkg::OP_RESULT: begin
        // a result with nothing outstanding is dropped
        if (awaiting_answer) begin
          awaiting_answer_next = 1'b0;
          if (evt.flag) begin
            has_synced_next     = 1'b1;
            last_sync_time_next = evt.now_ms;
            if (success_tally != srbs_pkg::TALLY_MAX) begin
              success_tally_next = success_tally + CW'(1);
            end
            failure_tally_next = '0;
            retry_delay_next   = act_base;
            next_due_time_next = evt.now_ms + act_interval;
            due_diff_next      = act_interval;
            since_next         = '0;
          end else begin
            if (failure_tally != srbs_pkg::TALLY_MAX) begin
              failure_tally_next = failure_tally + CW'(1);
            end
            next_due_time_next = evt.now_ms + retry_delay;
            due_diff_next      = retry_delay;
            // double the delay, or stop at the cap
            retry_delay_next   = (retry_delay > (act_cap >> 1)) ? act_cap
                                                                : (retry_delay << 1);
          end
        end
      end
      srbs_pkg::OP_APPLY: begin
        act_enabled_next  = sync_enabled;
        act_interval_next = interval_cl;
        act_base_next     = base_cl;
        act_cap_next      = cap_cl;
        act_gap_next      = relink_gap;
        retry_delay_next  = base_cl;
        if (has_synced) begin
          next_due_time_next = last_sync_time + interval_cl;
          due_diff_next      = interval_cl - since_cur;
        end else begin
          next_due_time_next = evt.now_ms;
          due_diff_next      = '0;
        end
      end
      default: ;
    endcase

    // time to the next sync, from the state as it stands after the event
    if (!act_enabled_next || !link_usable_next) begin
      until_next = srbs_pkg::NEVER;
    end else if (awaiting_answer_next || reached_by_diff(due_diff_next)) begin
      until_next = '0;
    end else begin
      until_next = due_diff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_enabled     <= 1'b0;
      act_interval    <= srbs_pkg::RST_INTERVAL;
      act_base        <= srbs_pkg::RST_RETRY_BASE;
      act_cap         <= srbs_pkg::RST_RETRY_CAP;
      act_gap         <= srbs_pkg::RST_RELINK_GAP;
      link_usable     <= 1'b0;
      awaiting_answer <= 1'b0;
      has_synced      <= 1'b0;
      last_sync_time  <= '0;
      next_due_time   <= '0;
      retry_delay     <= srbs_pkg::RST_RETRY_DELAY;
      success_tally   <= '0;
      failure_tally   <= '0;
    end else if (evt_accept) begin
      act_enabled     <= act_enabled_next;
      act_interval    <= act_interval_next;
      act_base        <= act_base_next;
      act_cap         <= act_cap_next;
      act_gap         <= act_gap_next;
      link_usable     <= link_usable_next;
      awaiting_answer <= awaiting_answer_next;
      has_synced      <= has_synced_next;
      last_sync_time  <= last_sync_time_next;
      next_due_time   <= next_due_time_next;
      retry_delay     <= retry_delay_next;
      success_tally   <= success_tally_next;
      failure_tally   <= failure_tally_next;
    end
  end

  // status output register
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (evt_accept) begin
      status_valid <= 1'b1;
    end else if (status.ready) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_accept) begin
      status.sync_request    <= req_next;
      status.since_last_sync <= since_next;
      status.next_sync_in    <= until_next;
      status.success_count   <= success_tally_next;
      status.failure_count   <= failure_tally_next;
      status.synced_ever     <= has_synced_next;
    end
  end

  assign status.valid = status_valid;

  // a granted tick leaves a request outstanding
  a_tick_sets_outstanding: assert property (@(posedge clk) disable iff (rst)
    evt_accept && req_next |=> awaiting_answer)
    else $error("tick granted a sync but no request is outstanding");

  // retry delay stays between the floor and the active cap
  a_retry_bounds: assert property (@(posedge clk) disable iff (rst)
    retry_delay >= srbs_pkg::FLOOR_MS && retry_delay <= act_cap)
    else $error("retry delay out of bounds");

  // only ticks may report a sync request
  a_req_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    evt_accept && evt.opcode != srbs_pkg::OP_TICK |=> !status.sync_request)
    else $error("sync request reported for an event other than a tick");

  // a good sync is never forgotten
  a_synced_sticky: assert property (@(posedge clk) disable iff (rst)
    has_synced |=> has_synced)
    else $error("sync history lost");

endmodule
